// ----- sv/osta_pkg.sv -----
// ----------------------------------------------------------------------------
// osta_pkg
// Shared types and codes of the slot table allocator: request and response
// words, configuration registers, action and status codes, sequencer states.
// ----------------------------------------------------------------------------
package osta_pkg;

	localparam int ACTION_W = 3;
	localparam int ID_W     = 10;
	localparam int VALUE_W  = 32;
	localparam int SPAN_W   = 33;
	localparam int STATUS_W = 2;
	localparam int LIMIT_W  = 11;

	localparam logic [ACTION_W-1:0] ACT_ADD         = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_REMOVE      = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_SHRINK      = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_READ_SIZE   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_READ_OFFSET = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_BAD_ID = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_GROW   = 2'd3;

	localparam logic CFG_ENTRY_LIMIT = 1'b0;
	localparam logic CFG_BASE_OFFSET = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;
	localparam logic [VALUE_W-1:0] BASE_RESET  = 32'd2097152;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [ID_W-1:0]     entry_id;
		logic [VALUE_W-1:0]  entry_offset;
		logic [VALUE_W-1:0]  entry_size;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     out_id;
		logic [VALUE_W-1:0]  out_value;
		logic [SPAN_W-1:0]   tail_end;
		logic [SPAN_W-1:0]   used_span;
		logic                is_empty;
	} rsp_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] entry_limit;
		logic [VALUE_W-1:0] base_offset;
	} cfg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD_TAKE,
		S_ADD_LINK,
		S_EVAL,
		S_DEL_NEXT,
		S_DEL_PREV,
		S_DONE
	} seq_state_t;

endpackage

// ----- sv/osta_ram.sv -----
// ----------------------------------------------------------------------------
// osta_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module osta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/osta_ctrl.sv -----
// ----------------------------------------------------------------------------
// osta_ctrl
// Sequencer of the slot table: owns the link and record memories, the free
// list head, the fresh mark and the list ends, and builds one response word
// per request.
// ----------------------------------------------------------------------------
module osta_ctrl #(
	parameter int ENTRY_COUNT = 1024,
	parameter int OFFSET_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  osta_pkg::cfg_t cfg,
	input  logic           req_valid,
	output logic           req_stall,
	input  osta_pkg::req_t req,
	input  logic           rsp_free,
	output logic           rsp_load,
	output osta_pkg::rsp_t rsp_next
);

	localparam int IDW = $clog2(ENTRY_COUNT);
	localparam int CW  = IDW + 1;
	localparam int MW  = (CW > osta_pkg::LIMIT_W) ? CW : osta_pkg::LIMIT_W;
	localparam int LW  = 1 + 2 * IDW;
	localparam int DW  = 2 * OFFSET_BITS;

	typedef struct packed {
		logic           live;
		logic [IDW-1:0] nxt;
		logic [IDW-1:0] prv;
	} link_t;

	typedef struct packed {
		logic [OFFSET_BITS-1:0] start;
		logic [OFFSET_BITS-1:0] len;
	} rec_t;

	function automatic logic [osta_pkg::SPAN_W-1:0] end_of(
		input logic [OFFSET_BITS-1:0] a,
		input logic [OFFSET_BITS-1:0] b
	);
		logic [OFFSET_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return osta_pkg::SPAN_W'(sum);
	endfunction

	osta_pkg::seq_state_t state_q, state_d;
	osta_pkg::req_t req_q;

	logic [IDW-1:0] free_top_q, first_q, last_q;
	logic [CW-1:0]  fresh_q;
	logic [IDW-1:0] slot_q, nb_next_q, nb_prev_q;
	logic [osta_pkg::SPAN_W-1:0]   tail_q;
	logic [osta_pkg::STATUS_W-1:0] res_status_q;
	logic [osta_pkg::ID_W-1:0]     res_id_q;
	logic [osta_pkg::VALUE_W-1:0]  res_val_q;

	logic           l_we, l_re, d_we, d_re;
	logic [IDW-1:0] l_waddr, l_raddr, d_waddr, d_raddr;
	link_t          l_wdata, l_rd;
	rec_t           d_wdata, d_rd;

	logic                   accept;
	logic [IDW-1:0]         eval_id, add_slot;
	logic [MW-1:0]          usable;
	logic                   full, id_ok;
	logic [OFFSET_BITS-1:0] new_off, req_len;
	logic [osta_pkg::SPAN_W-1:0] tail_now;

	osta_ram #(.WIDTH(LW), .DEPTH(ENTRY_COUNT)) u_link_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (l_wdata),
		.re    (l_re),
		.raddr (l_raddr),
		.rdata (l_rd)
	);

	osta_ram #(.WIDTH(DW), .DEPTH(ENTRY_COUNT)) u_rec_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (d_re),
		.raddr (d_raddr),
		.rdata (d_rd)
	);

	assign accept   = req_valid && !req_stall;
	assign eval_id  = IDW'(req_q.entry_id);
	assign new_off  = OFFSET_BITS'(req_q.entry_offset);
	assign req_len  = OFFSET_BITS'(req_q.entry_size);
	assign usable   = (MW'(cfg.entry_limit) > MW'(ENTRY_COUNT)) ?
		MW'(ENTRY_COUNT) : MW'(cfg.entry_limit);
	assign full     = (free_top_q == '0) && (MW'(fresh_q) >= usable);
	assign add_slot = (free_top_q != '0) ? free_top_q : IDW'(fresh_q);

	// Slots at or above the fresh mark were never written, so their live bit
	// in memory is meaningless and the fresh mark stands in for it.
	assign id_ok = (req_q.entry_id != '0) &&
		(MW'(req_q.entry_id) < MW'(fresh_q)) && l_rd.live;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			osta_pkg::S_IDLE: begin
				if (accept) begin
					if (req.action == osta_pkg::ACT_ADD) begin
						state_d = osta_pkg::S_ADD_TAKE;
					end else if (req.action == osta_pkg::ACT_REMOVE ||
						req.action == osta_pkg::ACT_SHRINK ||
						req.action == osta_pkg::ACT_READ_SIZE ||
						req.action == osta_pkg::ACT_READ_OFFSET) begin
						state_d = osta_pkg::S_EVAL;
					end else begin
						state_d = osta_pkg::S_DONE;
					end
				end
			end
			osta_pkg::S_ADD_TAKE: begin
				if (!full && last_q != '0) begin
					state_d = osta_pkg::S_ADD_LINK;
				end else begin
					state_d = osta_pkg::S_DONE;
				end
			end
			osta_pkg::S_ADD_LINK: state_d = osta_pkg::S_DONE;
			osta_pkg::S_EVAL: begin
				if (id_ok && req_q.action == osta_pkg::ACT_REMOVE &&
					(l_rd.nxt != '0 || l_rd.prv != '0)) begin
					state_d = osta_pkg::S_DEL_NEXT;
				end else begin
					state_d = osta_pkg::S_DONE;
				end
			end
			osta_pkg::S_DEL_NEXT: begin
				if (nb_next_q != '0 && nb_prev_q != '0) begin
					state_d = osta_pkg::S_DEL_PREV;
				end else begin
					state_d = osta_pkg::S_DONE;
				end
			end
			osta_pkg::S_DEL_PREV: state_d = osta_pkg::S_DONE;
			osta_pkg::S_DONE: begin
				if (rsp_free) begin
					state_d = osta_pkg::S_IDLE;
				end
			end
			default: state_d = osta_pkg::S_IDLE;
		endcase
	end

	// Memory ports and handshake outputs
	always_comb begin
		req_stall = (state_q != osta_pkg::S_IDLE);
		rsp_load  = (state_q == osta_pkg::S_DONE) && rsp_free;
		l_we      = 1'b0;
		l_waddr   = '0;
		l_wdata   = '0;
		l_re      = 1'b0;
		l_raddr   = '0;
		d_we      = 1'b0;
		d_waddr   = '0;
		d_wdata   = '0;
		d_re      = 1'b0;
		d_raddr   = '0;
		unique case (state_q)
			osta_pkg::S_IDLE: begin
				l_re    = accept;
				l_raddr = (req.action == osta_pkg::ACT_ADD) ?
					free_top_q : IDW'(req.entry_id);
				d_re    = accept;
				d_raddr = IDW'(req.entry_id);
			end
			osta_pkg::S_ADD_TAKE: begin
				if (!full) begin
					l_we    = 1'b1;
					l_waddr = add_slot;
					l_wdata = '{live: 1'b1, nxt: '0, prv: last_q};
					d_we    = 1'b1;
					d_waddr = add_slot;
					d_wdata = '{start: new_off, len: req_len};
					l_re    = (last_q != '0);
					l_raddr = last_q;
				end
			end
			osta_pkg::S_ADD_LINK: begin
				l_we    = 1'b1;
				l_waddr = last_q;
				l_wdata = '{live: l_rd.live, nxt: slot_q, prv: l_rd.prv};
			end
			osta_pkg::S_EVAL: begin
				if (id_ok && req_q.action == osta_pkg::ACT_SHRINK &&
					req_len <= d_rd.len) begin
					d_we    = 1'b1;
					d_waddr = eval_id;
					d_wdata = '{start: d_rd.start, len: req_len};
				end
				if (id_ok && req_q.action == osta_pkg::ACT_REMOVE) begin
					// The freed slot keeps the free list link in its next field.
					l_we    = 1'b1;
					l_waddr = eval_id;
					l_wdata = '{live: 1'b0, nxt: free_top_q, prv: l_rd.prv};
					l_re    = (l_rd.nxt != '0) || (l_rd.prv != '0);
					l_raddr = (l_rd.nxt != '0) ? l_rd.nxt : l_rd.prv;
					d_re    = 1'b1;
					d_raddr = l_rd.prv;
				end
			end
			osta_pkg::S_DEL_NEXT: begin
				l_we = 1'b1;
				if (nb_next_q != '0) begin
					l_waddr = nb_next_q;
					l_wdata = '{live: l_rd.live, nxt: l_rd.nxt, prv: nb_prev_q};
					l_re    = (nb_prev_q != '0);
					l_raddr = nb_prev_q;
				end else begin
					l_waddr = nb_prev_q;
					l_wdata = '{live: l_rd.live, nxt: '0, prv: l_rd.prv};
				end
			end
			osta_pkg::S_DEL_PREV: begin
				l_we    = 1'b1;
				l_waddr = nb_prev_q;
				l_wdata = '{live: l_rd.live, nxt: nb_next_q, prv: l_rd.prv};
			end
			osta_pkg::S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= osta_pkg::S_IDLE;
			free_top_q <= '0;
			fresh_q    <= CW'(1);
			first_q    <= '0;
			last_q     <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				osta_pkg::S_ADD_TAKE: begin
					if (!full) begin
						if (free_top_q != '0) begin
							free_top_q <= l_rd.nxt;
						end else begin
							fresh_q <= fresh_q + CW'(1);
						end
						if (last_q == '0) begin
							first_q <= add_slot;
							last_q  <= add_slot;
						end
					end
				end
				osta_pkg::S_ADD_LINK: last_q <= slot_q;
				osta_pkg::S_EVAL: begin
					if (id_ok && req_q.action == osta_pkg::ACT_REMOVE) begin
						free_top_q <= eval_id;
						if (l_rd.nxt == '0) begin
							last_q <= l_rd.prv;
						end
						if (l_rd.prv == '0) begin
							first_q <= l_rd.nxt;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Request copy, results and tail end
	always_ff @(posedge clk) begin
		unique case (state_q)
			osta_pkg::S_IDLE: begin
				if (accept) begin
					req_q        <= req;
					res_status_q <= osta_pkg::STAT_OK;
					res_id_q     <= '0;
					res_val_q    <= '0;
				end
			end
			osta_pkg::S_ADD_TAKE: begin
				if (full) begin
					res_status_q <= osta_pkg::STAT_FULL;
				end else begin
					slot_q   <= add_slot;
					res_id_q <= osta_pkg::ID_W'(add_slot);
					tail_q   <= end_of(new_off, req_len);
				end
			end
			osta_pkg::S_EVAL: begin
				if (!id_ok) begin
					res_status_q <= osta_pkg::STAT_BAD_ID;
				end else begin
					unique case (req_q.action)
						osta_pkg::ACT_REMOVE: begin
							res_val_q <= osta_pkg::VALUE_W'(d_rd.len);
							nb_next_q <= l_rd.nxt;
							nb_prev_q <= l_rd.prv;
						end
						osta_pkg::ACT_SHRINK: begin
							if (req_len > d_rd.len) begin
								res_status_q <= osta_pkg::STAT_GROW;
							end else begin
								res_val_q <= osta_pkg::VALUE_W'(d_rd.len - req_len);
								if (eval_id == last_q) begin
									tail_q <= end_of(d_rd.start, req_len);
								end
							end
						end
						osta_pkg::ACT_READ_SIZE: begin
							res_val_q <= osta_pkg::VALUE_W'(d_rd.len);
						end
						osta_pkg::ACT_READ_OFFSET: begin
							res_val_q <= osta_pkg::VALUE_W'(d_rd.start);
						end
						default: begin
						end
					endcase
				end
			end
			osta_pkg::S_DEL_NEXT: begin
				// The removed record was the tail: its predecessor's record was
				// fetched together with the neighbor links.
				if (nb_next_q == '0) begin
					tail_q <= end_of(d_rd.start, d_rd.len);
				end
			end
			default: begin
			end
		endcase
	end

	assign tail_now = (last_q == '0) ? osta_pkg::SPAN_W'(cfg.base_offset) : tail_q;

	always_comb begin
		rsp_next.status    = res_status_q;
		rsp_next.out_id    = res_id_q;
		rsp_next.out_value = res_val_q;
		rsp_next.tail_end  = tail_now;
		rsp_next.used_span = tail_now - osta_pkg::SPAN_W'(cfg.base_offset);
		rsp_next.is_empty  = (first_q == '0);
	end

endmodule

// ----- sv/object_slot_table_allocator.sv -----
// ----------------------------------------------------------------------------
// object_slot_table_allocator
// Slot table allocator: hands out slot ids from a free list or a fresh mark,
// keeps records in a doubly linked list in on-chip RAM, in the order they were added.
// ----------------------------------------------------------------------------
//
//   channel  direction  word    handshake
//   req      in         req_t   req_valid / req_stall
//   rsp      out        rsp_t   rsp_valid / rsp_stall
//   cfg      in         32 bit  cfg_we, cfg_index (write only)
//
// The response word is loaded into the output register in the last step of
// its request, and the next request can be taken in the cycle after the load;
// no new request is taken before that. Each step is a read or a
// read-modify-write of the link and record RAMs, one access per RAM port a
// cycle; an unknown action is the shortest case and remove with both
// neighbors linked is the longest.
// The next request is taken while a response still waits in the output
// register. After reset the table is empty and requests are taken at once.
// A stalled response holds the sequencer in its last step.
//
module object_slot_table_allocator #(
	parameter int ENTRY_COUNT = 1024,
	parameter int OFFSET_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [osta_pkg::VALUE_W-1:0]  cfg_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  osta_pkg::req_t                req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output osta_pkg::rsp_t                rsp
);

	osta_pkg::cfg_t cfg_q;
	osta_pkg::rsp_t rsp_next, rsp_q;
	logic           rsp_valid_q, rsp_free, rsp_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.entry_limit <= osta_pkg::LIMIT_RESET;
			cfg_q.base_offset <= osta_pkg::BASE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				osta_pkg::CFG_ENTRY_LIMIT: begin
					cfg_q.entry_limit <= cfg_data[osta_pkg::LIMIT_W-1:0];
				end
				osta_pkg::CFG_BASE_OFFSET: begin
					cfg_q.base_offset <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	osta_ctrl #(
		.ENTRY_COUNT (ENTRY_COUNT),
		.OFFSET_BITS (OFFSET_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_free  (rsp_free),
		.rsp_load  (rsp_load),
		.rsp_next  (rsp_next)
	);

	// The output register frees up in the same cycle its word is taken.
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- sim/slot_table_checker.sv -----
// ----------------------------------------------------------------------------
// slot_table_checker
// Watches the request, response and register ports of the slot table
// allocator. It keeps its own copy of the slot table and the linked list,
// works out the response word of every accepted request and compares it
// field by field with the words that the block delivers, in order.
// ----------------------------------------------------------------------------
module slot_table_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [osta_pkg::VALUE_W-1:0]  cfg_data,
	input  logic                          req_valid,
	input  logic                          req_stall,
	input  osta_pkg::req_t                req,
	input  logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  osta_pkg::rsp_t                rsp,
	output int                            errors,
	output int                            outstanding
);

	localparam int SLOTS = 1024;

	bit [osta_pkg::ID_W-1:0]    link_fwd  [SLOTS];
	bit [osta_pkg::ID_W-1:0]    link_back [SLOTS];
	bit [osta_pkg::VALUE_W-1:0] rec_start [SLOTS];
	bit [osta_pkg::VALUE_W-1:0] rec_len   [SLOTS];
	bit                         rec_live  [SLOTS];
	bit [osta_pkg::ID_W-1:0]    spare_top;
	bit [osta_pkg::ID_W-1:0]    list_head;
	bit [osta_pkg::ID_W-1:0]    list_tail;
	int unsigned                fresh_next;
	bit [osta_pkg::LIMIT_W-1:0] limit_reg;
	bit [osta_pkg::VALUE_W-1:0] base_reg;
	osta_pkg::rsp_t             replies_due [$];

	// Applies one request to the shadow table and returns the word it should produce.
	task automatic table_step(input osta_pkg::req_t r, output osta_pkg::rsp_t e);
		int unsigned               slot;
		int unsigned               usable;
		bit [osta_pkg::ID_W-1:0]   id;
		bit [osta_pkg::ID_W-1:0]   n;
		bit [osta_pkg::ID_W-1:0]   p;
		bit [osta_pkg::SPAN_W-1:0] tail;
		e = '0;
		id = r.entry_id;
		if (r.action == osta_pkg::ACT_ADD) begin
			slot = 0;
			usable = (limit_reg > SLOTS) ? SLOTS : limit_reg;
			if (spare_top != 0) begin
				slot = spare_top;
				spare_top = link_fwd[slot];
			end else if (fresh_next < usable) begin
				slot = fresh_next;
				fresh_next++;
			end
			if (slot == 0) begin
				e.status = osta_pkg::STAT_FULL;
			end else begin
				rec_start[slot] = r.entry_offset;
				rec_len[slot] = r.entry_size;
				rec_live[slot] = 1'b1;
				link_back[slot] = list_tail;
				link_fwd[slot] = '0;
				if (list_tail == 0)
					list_head = osta_pkg::ID_W'(slot);
				else
					link_fwd[list_tail] = osta_pkg::ID_W'(slot);
				list_tail = osta_pkg::ID_W'(slot);
				e.out_id = osta_pkg::ID_W'(slot);
			end
		end else if (r.action == osta_pkg::ACT_REMOVE ||
				r.action == osta_pkg::ACT_SHRINK ||
				r.action == osta_pkg::ACT_READ_SIZE ||
				r.action == osta_pkg::ACT_READ_OFFSET) begin
			if (id == 0 || !rec_live[id]) begin
				e.status = osta_pkg::STAT_BAD_ID;
			end else if (r.action == osta_pkg::ACT_REMOVE) begin
				n = link_fwd[id];
				p = link_back[id];
				if (n == 0)
					list_tail = p;
				else
					link_back[n] = p;
				if (p == 0)
					list_head = n;
				else
					link_fwd[p] = n;
				link_fwd[id] = spare_top;
				spare_top = id;
				rec_live[id] = 1'b0;
				e.out_value = rec_len[id];
			end else if (r.action == osta_pkg::ACT_SHRINK) begin
				if (r.entry_size > rec_len[id]) begin
					e.status = osta_pkg::STAT_GROW;
				end else begin
					e.out_value = rec_len[id] - r.entry_size;
					rec_len[id] = r.entry_size;
				end
			end else if (r.action == osta_pkg::ACT_READ_SIZE) begin
				e.out_value = rec_len[id];
			end else begin
				e.out_value = rec_start[id];
			end
		end
		if (list_tail == 0)
			tail = {1'b0, base_reg};
		else
			tail = {1'b0, rec_start[list_tail]} + {1'b0, rec_len[list_tail]};
		e.tail_end = tail;
		e.used_span = tail - {1'b0, base_reg};
		e.is_empty = (list_head == 0);
	endtask

	task automatic compare_field(input string name,
			input logic [osta_pkg::SPAN_W-1:0] want,
			input logic [osta_pkg::SPAN_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : watch
		osta_pkg::rsp_t want;
		osta_pkg::rsp_t due;
		if (!arst_n) begin
			for (int k = 0; k < SLOTS; k++) begin
				link_fwd[k] = '0;
				link_back[k] = '0;
				rec_start[k] = '0;
				rec_len[k] = '0;
				rec_live[k] = 1'b0;
			end
			spare_top = '0;
			list_head = '0;
			list_tail = '0;
			fresh_next = 1;
			limit_reg = osta_pkg::LIMIT_RESET;
			base_reg = osta_pkg::BASE_RESET;
			replies_due.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == osta_pkg::CFG_ENTRY_LIMIT)
					limit_reg = cfg_data[osta_pkg::LIMIT_W-1:0];
				else
					base_reg = cfg_data;
			end
			if (req_valid && !req_stall) begin
				table_step(req, want);
				replies_due.push_back(want);
			end
			if (rsp_valid && !rsp_stall) begin
				if (replies_due.size() == 0) begin
					errors++;
					$display("%0t: response word with nothing expected, actual %p",
						$time, rsp);
				end else begin
					due = replies_due.pop_front();
					compare_field("status", osta_pkg::SPAN_W'(due.status),
						osta_pkg::SPAN_W'(rsp.status));
					compare_field("out_id", osta_pkg::SPAN_W'(due.out_id),
						osta_pkg::SPAN_W'(rsp.out_id));
					compare_field("out_value", osta_pkg::SPAN_W'(due.out_value),
						osta_pkg::SPAN_W'(rsp.out_value));
					compare_field("tail_end", due.tail_end, rsp.tail_end);
					compare_field("used_span", due.used_span, rsp.used_span);
					compare_field("is_empty", osta_pkg::SPAN_W'(due.is_empty),
						osta_pkg::SPAN_W'(rsp.is_empty));
				end
			end
			outstanding = replies_due.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives the slot table allocator through a directed opening and several
// random phases under different slot limits and base offsets, with random
// gaps on the request side and random stalls on the response side. The
// checker beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [osta_pkg::ACTION_W-1:0] ACT_SPARE_LO =
		osta_pkg::ACT_READ_OFFSET + 3'd1;
	localparam logic [osta_pkg::ACTION_W-1:0] ACT_SPARE_HI = '1;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic                         cfg_index;
	logic [osta_pkg::VALUE_W-1:0] cfg_data;
	logic                         req_valid;
	logic                         req_stall;
	osta_pkg::req_t               req;
	logic                         rsp_valid;
	logic                         rsp_stall;
	osta_pkg::rsp_t               rsp;
	int                           errors;
	int                           outstanding;
	bit                           calm;
	bit                           squeeze;

	object_slot_table_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	slot_table_checker audit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("FAIL");
		$finish;
	end

	// Response side: random stalls, none while calm, and one long hold-off on request.
	initial begin : drain
		int hold;
		hold = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				hold--;
			end else if (squeeze) begin
				squeeze = 1'b0;
				hold = 80;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= !calm && ($urandom_range(99) < 17);
			end
		end
	end

	function automatic osta_pkg::req_t make_req(input logic [osta_pkg::ACTION_W-1:0] a,
			input int id, input logic [osta_pkg::VALUE_W-1:0] off,
			input logic [osta_pkg::VALUE_W-1:0] size);
		osta_pkg::req_t r;
		r.action = a;
		r.entry_id = osta_pkg::ID_W'(id);
		r.entry_offset = off;
		r.entry_size = size;
		return r;
	endfunction

	// Offers one word and holds it until the block takes it.
	task automatic send(input osta_pkg::req_t r);
		if (!calm && $urandom_range(99) < 17) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic configure(input logic [osta_pkg::VALUE_W-1:0] limit_word,
			input logic [osta_pkg::VALUE_W-1:0] base);
		wait_drained();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= osta_pkg::CFG_ENTRY_LIMIT;
		cfg_data <= limit_word;
		@(posedge clk);
		cfg_index <= osta_pkg::CFG_BASE_OFFSET;
		cfg_data <= base;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly adds and operations on low slot ids, which are likely to be live,
	// plus unknown actions and stray ids across the whole id range.
	task automatic random_phase(input int count, input int add_w, input int rem_w,
			input int id_cap, input bit widen);
		osta_pkg::req_t r;
		int             pick;
		int             sel;
		int             cap;
		for (int i = 0; i < count; i++) begin
			cap = widen ? id_cap + i * add_w / 100 : id_cap;
			if (cap > 1023)
				cap = 1023;
			r.entry_id = osta_pkg::ID_W'($urandom_range(0, cap));
			pick = $urandom_range(99);
			if (pick < add_w) begin
				r.action = osta_pkg::ACT_ADD;
			end else if (pick < add_w + rem_w) begin
				r.action = osta_pkg::ACT_REMOVE;
			end else if (pick < 94) begin
				case ($urandom_range(2))
					0: r.action = osta_pkg::ACT_SHRINK;
					1: r.action = osta_pkg::ACT_READ_SIZE;
					default: r.action = osta_pkg::ACT_READ_OFFSET;
				endcase
			end else if (pick < 97) begin
				r.action = ACT_SPARE_LO + osta_pkg::ACTION_W'($urandom_range(0, 2));
			end else begin
				r.action = osta_pkg::ACT_REMOVE +
					osta_pkg::ACTION_W'($urandom_range(0, 3));
				r.entry_id = osta_pkg::ID_W'($urandom);
			end
			sel = $urandom_range(9);
			r.entry_offset = (sel < 6) ? $urandom :
				(sel < 8) ? $urandom_range(0, 4095) : ~$urandom_range(0, 4095);
			sel = $urandom_range(9);
			if (r.action == osta_pkg::ACT_SHRINK)
				r.entry_size = (sel < 6) ? $urandom_range(0, 4095) :
					(sel < 8) ? 32'd0 : $urandom;
			else
				r.entry_size = (sel < 5) ? $urandom_range(1, 65535) :
					(sel < 8) ? $urandom : (sel < 9) ? 32'd0 : 32'hFFFF_FFFF;
			send(r);
		end
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = osta_pkg::CFG_ENTRY_LIMIT;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		squeeze = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening under the reset register values.
		send(make_req(osta_pkg::ACT_READ_SIZE, 0, 0, 0));
		send(make_req(osta_pkg::ACT_REMOVE, 5, 0, 0));
		send(make_req(osta_pkg::ACT_ADD, 0, 32'h0020_0000, 32'h100));
		// The tail end needs the carry bit here.
		send(make_req(osta_pkg::ACT_ADD, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		// Appended even though its offset lies below the current tail.
		send(make_req(osta_pkg::ACT_ADD, 0, 0, 0));
		send(make_req(osta_pkg::ACT_READ_OFFSET, 2, 0, 0));
		send(make_req(osta_pkg::ACT_READ_SIZE, 2, 0, 0));
		send(make_req(osta_pkg::ACT_SHRINK, 1, 0, 32'h200));
		send(make_req(osta_pkg::ACT_SHRINK, 1, 0, 32'h80));
		send(make_req(osta_pkg::ACT_SHRINK, 1, 0, 32'h80));
		send(make_req(osta_pkg::ACT_REMOVE, 2, 0, 0));
		send(make_req(osta_pkg::ACT_REMOVE, 3, 0, 0));
		send(make_req(osta_pkg::ACT_READ_SIZE, 2, 0, 0));
		// These two adds must come back from the free list, last freed first.
		send(make_req(osta_pkg::ACT_ADD, 0, 32'h1000, 32'h10));
		send(make_req(osta_pkg::ACT_ADD, 0, 32'h2000, 32'h20));
		send(make_req(ACT_SPARE_LO, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send(make_req(ACT_SPARE_HI, 2, 0, 0));
		send(make_req(osta_pkg::ACT_REMOVE, 1, 0, 0));
		send(make_req(osta_pkg::ACT_SHRINK, 3, 0, 0));
		send(make_req(osta_pkg::ACT_REMOVE, 3, 0, 0));
		send(make_req(osta_pkg::ACT_REMOVE, 2, 0, 0));
		send(make_req(osta_pkg::ACT_READ_OFFSET, 1023, 0, 0));
		send(make_req(osta_pkg::ACT_SHRINK, 0, 0, 0));
		send(make_req(osta_pkg::ACT_REMOVE, 2, 0, 0));

		// Small table that fills up often; the upper limit bits carry junk.
		configure({21'($urandom), 11'd8}, 32'd0);
		random_phase(220, 45, 20, 10, 1'b0);

		// Fresh slots unusable: only the free list serves adds.
		configure(32'd0, 32'hFFFF_FFFF);
		random_phase(120, 40, 25, 10, 1'b0);

		configure(32'd48, $urandom);
		calm = 1'b1;
		random_phase(150, 50, 20, 50, 1'b0);
		calm = 1'b0;
		squeeze = 1'b1;
		random_phase(150, 50, 20, 50, 1'b0);

		// Limit lowered below live records and free slots.
		configure(32'd2, 32'($urandom_range(0, 4095)));
		random_phase(60, 40, 30, 50, 1'b0);

		// Limit above the slot count, mostly adds so the table grows deep.
		configure(32'd2047, $urandom);
		random_phase(450, 75, 8, 50, 1'b1);

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/osta_pkg.sv
sv/osta_ram.sv
sv/osta_ctrl.sv
sv/object_slot_table_allocator.sv
sim/slot_table_checker.sv
sim/testbench.sv
